// File: design/ffa_pkg.sv
package ffa_pkg;

    // Table depth and address arithmetic
    localparam int MAX_ENTRIES     = 64;
    localparam int ADDR_BITS       = 32;
    localparam int HEADER_BYTES    = 32;
    localparam int MANAGER_BYTES   = 48;
    localparam logic [31:0] HEAP_SIZE_RESET = 32'd1048576;

    // Offsets are carried wide enough for the address space or a full word
    localparam int OFF_W = (ADDR_BITS > 32) ? ADDR_BITS : 32;
    localparam logic [OFF_W-1:0] OFF_MASK = {OFF_W{1'b1}} >> (OFF_W - ADDR_BITS);
    localparam logic [31:0] ABS_MASK = (ADDR_BITS >= 32) ? 32'hFFFF_FFFF
                                     : 32'((64'd1 << ADDR_BITS) - 64'd1);

    // Request opcodes
    localparam logic OP_ALLOC = 1'b0;
    localparam logic OP_FREE  = 1'b1;

    // Result status codes
    typedef logic [2:0] status_t;
    localparam status_t ST_OK       = 3'd0;
    localparam status_t ST_ZERO     = 3'd1;
    localparam status_t ST_NOSPACE  = 3'd2;
    localparam status_t ST_FULL     = 3'd3;
    localparam status_t ST_NOTFOUND = 3'd4;
    localparam status_t ST_DOUBLE   = 3'd5;

    // Configuration register indexes
    localparam int CFG_IDX_W = 1;
    localparam logic [CFG_IDX_W-1:0] CFG_HEAP_BASE = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_HEAP_SIZE = 1'b1;

    // One table entry as held in the RAM
    typedef struct packed {
        logic        free;
        logic [31:0] size;
        logic [31:0] start;
    } entry_t;

    localparam int ENTRY_W = $bits(entry_t);

    // Request as held during the scan
    typedef struct packed {
        logic             op;
        logic [31:0]      size;
        logic [OFF_W-1:0] off;
    } req_t;

endpackage

// File: design/ffa_req_if.sv
interface ffa_req_if;
    logic        valid;
    logic        ready;
    logic        opcode;
    logic [31:0] req_size;
    logic [31:0] release_addr;

    modport source (output valid, output opcode, output req_size, output release_addr,
                    input ready);
    modport sink   (input valid, input opcode, input req_size, input release_addr,
                    output ready);
endinterface

// File: design/ffa_rsp_if.sv
interface ffa_rsp_if;
    logic        valid;
    logic        ready;
    logic [31:0] block_addr;
    logic [2:0]  status;
    logic [31:0] used_total;
    logic [31:0] free_total;

    modport source (output valid, output block_addr, output status, output used_total,
                    output free_total, input ready);
    modport sink   (input valid, input block_addr, input status, input used_total,
                    input free_total, output ready);
endinterface

// File: design/ffa_ram.sv
module ffa_ram #(
    parameter int WIDTH = ffa_pkg::ENTRY_W,
    parameter int DEPTH = ffa_pkg::MAX_ENTRIES
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// File: design/ffa_match.sv
module ffa_match (
    input  ffa_pkg::req_t   req,
    input  ffa_pkg::entry_t ent,
    output logic            hit
);

    // Allocate: first free block large enough. Free: block whose start matches.
    always_comb
    begin
        if (req.op == ffa_pkg::OP_FREE)
        begin
            hit = (ffa_pkg::OFF_W'(ent.start) == req.off);
        end
        else
        begin
            hit = ent.free && (ent.size >= req.size);
        end
    end

endmodule

// File: design/first_fit_block_allocator.sv
// Sequence: a zero-size allocate goes from acceptance to the result state without touching
//   the table; other requests scan, then hit or miss; the table RAM is walked one entry per cycle.
// Throughput: one request at a time; the next is taken once the result is registered.
// Reset: asynchronous, active low; empties the table, clears used bytes and sets
//   free bytes, heap_base and heap_size to their reset values.
module first_fit_block_allocator #(
    parameter int MAX_ENTRIES = ffa_pkg::MAX_ENTRIES
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_we,
    input  logic [ffa_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [31:0]                   cfg_data,
    ffa_req_if.sink                       req,
    ffa_rsp_if.source                     rsp
);

    localparam int IDX_W = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
    localparam int CNT_W = $clog2(MAX_ENTRIES + 1);
    localparam int OFF_W = ffa_pkg::OFF_W;

    // Sequencer states
    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_SCAN = 3'd1;
    localparam logic [2:0] S_HIT  = 3'd2;
    localparam logic [2:0] S_MISS = 3'd3;
    localparam logic [2:0] S_DONE = 3'd4;

    // Control state
    logic [2:0]       state_reg, state_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic [CNT_W-1:0] idx_reg, idx_next;
    logic             chk_valid_reg, chk_valid_next;
    logic [31:0]      used_reg, used_next;
    logic [31:0]      free_reg, free_next;
    logic [31:0]      heap_base_reg, heap_base_next;
    logic [31:0]      heap_size_reg, heap_size_next;
    logic             rsp_valid_reg, rsp_valid_next;

    // Payload
    ffa_pkg::req_t    req_reg, req_next;
    logic [IDX_W-1:0] chk_idx_reg, chk_idx_next;
    logic [IDX_W-1:0] hit_idx_reg, hit_idx_next;
    ffa_pkg::entry_t  hit_ent_reg, hit_ent_next;
    logic [32:0]      tail_end_reg, tail_end_next;
    logic [31:0]      res_addr_reg, res_addr_next;
    ffa_pkg::status_t res_status_reg, res_status_next;
    logic [31:0]      rsp_addr_reg, rsp_addr_next;
    ffa_pkg::status_t rsp_status_reg, rsp_status_next;
    logic [31:0]      rsp_used_reg, rsp_used_next;
    logic [31:0]      rsp_free_reg, rsp_free_next;

    // Table RAM and compare unit
    logic                    ram_we;
    logic [IDX_W-1:0]        ram_waddr;
    ffa_pkg::entry_t         ram_wentry;
    logic                    ram_re;
    logic [ffa_pkg::ENTRY_W-1:0] ram_rdata;
    ffa_pkg::entry_t         rd_ent;
    logic                    hit;

    // Scan and append helpers
    logic             issue;
    logic [OFF_W-1:0] rel_off;
    logic [32:0]      hdr;
    logic [33:0]      need;
    logic [31:0]      new_start;
    logic [32:0]      sum_abs;

    ffa_ram #(
        .WIDTH(ffa_pkg::ENTRY_W),
        .DEPTH(MAX_ENTRIES)
    ) u_ram (
        .clk  (clk),
        .we   (ram_we),
        .waddr(ram_waddr),
        .wdata(ram_wentry),
        .re   (ram_re),
        .raddr(idx_reg[IDX_W-1:0]),
        .rdata(ram_rdata)
    );

    assign rd_ent = ram_rdata;

    ffa_match u_match (
        .req(req_reg),
        .ent(rd_ent),
        .hit(hit)
    );

    // A read goes out while the walk index is still inside the table
    assign issue  = (idx_reg < count_reg);
    assign ram_re = (state_reg == S_SCAN) && issue;

    // Turn a release address back into an offset from heap_base
    assign rel_off = (OFF_W'(req.release_addr) - OFF_W'(heap_base_reg)) & ffa_pkg::OFF_MASK;

    // Header of a new block sits behind the last one, or behind the manager area
    assign hdr = (count_reg == '0) ? 33'(ffa_pkg::MANAGER_BYTES) : tail_end_reg;
    assign need = 34'(hdr) + 34'(ffa_pkg::HEADER_BYTES) + 34'(req_reg.size);
    assign new_start = 32'(hdr + 33'(ffa_pkg::HEADER_BYTES));

    // Absolute address of whichever block start the current state deals with
    assign sum_abs = {1'b0, heap_base_reg}
                   + {1'b0, (state_reg == S_HIT) ? hit_ent_reg.start : new_start};

    assign req.ready = (state_reg == S_IDLE);

    always_comb
    begin
        state_next      = state_reg;
        count_next      = count_reg;
        idx_next        = idx_reg;
        chk_valid_next  = chk_valid_reg;
        used_next       = used_reg;
        free_next       = free_reg;
        heap_base_next  = heap_base_reg;
        heap_size_next  = heap_size_reg;
        rsp_valid_next  = rsp_valid_reg;
        req_next        = req_reg;
        chk_idx_next    = chk_idx_reg;
        hit_idx_next    = hit_idx_reg;
        hit_ent_next    = hit_ent_reg;
        tail_end_next   = tail_end_reg;
        res_addr_next   = res_addr_reg;
        res_status_next = res_status_reg;
        rsp_addr_next   = rsp_addr_reg;
        rsp_status_next = rsp_status_reg;
        rsp_used_next   = rsp_used_reg;
        rsp_free_next   = rsp_free_reg;
        ram_we          = 1'b0;
        ram_waddr       = hit_idx_reg;
        ram_wentry      = hit_ent_reg;

        // Drop the held result once the consumer takes it
        if (rsp_valid_reg && rsp.ready)
        begin
            rsp_valid_next = 1'b0;
        end

        // Register writes; heap_size empties the table and resets the counters
        if (cfg_we)
        begin
            if (cfg_index == ffa_pkg::CFG_HEAP_BASE)
            begin
                heap_base_next = cfg_data;
            end
            else if (cfg_index == ffa_pkg::CFG_HEAP_SIZE)
            begin
                heap_size_next = cfg_data;
                count_next     = '0;
                used_next      = '0;
                free_next      = cfg_data;
            end
        end

        case (state_reg)
            S_IDLE:
            begin
                if (req.valid)
                begin
                    req_next.op   = req.opcode;
                    req_next.size = req.req_size;
                    req_next.off  = rel_off;
                    idx_next       = '0;
                    chk_valid_next = 1'b0;
                    if (req.opcode == ffa_pkg::OP_ALLOC && req.req_size == '0)
                    begin
                        // Zero-size allocate fails without touching the table
                        res_addr_next   = '0;
                        res_status_next = ffa_pkg::ST_ZERO;
                        state_next      = S_DONE;
                    end
                    else
                    begin
                        state_next = S_SCAN;
                    end
                end
            end

            S_SCAN:
            begin
                // Compare the entry read last cycle while the next read goes out
                if (chk_valid_reg && hit)
                begin
                    hit_ent_next = rd_ent;
                    hit_idx_next = chk_idx_reg;
                    state_next   = S_HIT;
                end
                else if (!issue)
                begin
                    state_next = S_MISS;
                end
                else
                begin
                    chk_valid_next = 1'b1;
                    chk_idx_next   = idx_reg[IDX_W-1:0];
                    idx_next       = idx_reg + CNT_W'(1);
                end
            end

            S_HIT:
            begin
                if (req_reg.op == ffa_pkg::OP_FREE && hit_ent_reg.free)
                begin
                    // Double free: leave the table alone
                    res_addr_next   = '0;
                    res_status_next = ffa_pkg::ST_DOUBLE;
                end
                else
                begin
                    ram_we          = 1'b1;
                    ram_wentry.free = (req_reg.op == ffa_pkg::OP_FREE);
                    if (req_reg.op == ffa_pkg::OP_FREE)
                    begin
                        used_next = used_reg - hit_ent_reg.size;
                        free_next = free_reg + hit_ent_reg.size;
                    end
                    else
                    begin
                        used_next = used_reg + hit_ent_reg.size;
                        free_next = free_reg - hit_ent_reg.size;
                    end
                    res_addr_next   = sum_abs[31:0] & ffa_pkg::ABS_MASK;
                    res_status_next = ffa_pkg::ST_OK;
                end
                state_next = S_DONE;
            end

            S_MISS:
            begin
                res_addr_next = '0;
                if (req_reg.op == ffa_pkg::OP_FREE)
                begin
                    res_status_next = ffa_pkg::ST_NOTFOUND;
                end
                else if (count_reg == CNT_W'(MAX_ENTRIES))
                begin
                    res_status_next = ffa_pkg::ST_FULL;
                end
                else if (need > 34'(heap_size_reg))
                begin
                    res_status_next = ffa_pkg::ST_NOSPACE;
                end
                else
                begin
                    // Append a block behind the last one
                    ram_we           = 1'b1;
                    ram_waddr        = count_reg[IDX_W-1:0];
                    ram_wentry.free  = 1'b0;
                    ram_wentry.size  = req_reg.size;
                    ram_wentry.start = new_start;
                    count_next       = count_reg + CNT_W'(1);
                    tail_end_next    = {1'b0, new_start} + {1'b0, req_reg.size};
                    used_next        = used_reg + req_reg.size;
                    free_next        = free_reg - req_reg.size;
                    res_addr_next    = sum_abs[31:0] & ffa_pkg::ABS_MASK;
                    res_status_next  = ffa_pkg::ST_OK;
                end
                state_next = S_DONE;
            end

            S_DONE:
            begin
                // Hold until the output register is free, then hand the result over
                if (!rsp_valid_reg || rsp.ready)
                begin
                    rsp_valid_next  = 1'b1;
                    rsp_addr_next   = res_addr_reg;
                    rsp_status_next = res_status_reg;
                    rsp_used_next   = used_reg;
                    rsp_free_next   = free_reg;
                    state_next      = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            idx_reg       <= '0;
            chk_valid_reg <= 1'b0;
            used_reg      <= '0;
            free_reg      <= ffa_pkg::HEAP_SIZE_RESET;
            heap_base_reg <= '0;
            heap_size_reg <= ffa_pkg::HEAP_SIZE_RESET;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            idx_reg       <= idx_next;
            chk_valid_reg <= chk_valid_next;
            used_reg      <= used_next;
            free_reg      <= free_next;
            heap_base_reg <= heap_base_next;
            heap_size_reg <= heap_size_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        req_reg        <= req_next;
        chk_idx_reg    <= chk_idx_next;
        hit_idx_reg    <= hit_idx_next;
        hit_ent_reg    <= hit_ent_next;
        tail_end_reg   <= tail_end_next;
        res_addr_reg   <= res_addr_next;
        res_status_reg <= res_status_next;
        rsp_addr_reg   <= rsp_addr_next;
        rsp_status_reg <= rsp_status_next;
        rsp_used_reg   <= rsp_used_next;
        rsp_free_reg   <= rsp_free_next;
    end

    assign rsp.valid      = rsp_valid_reg;
    assign rsp.block_addr = rsp_addr_reg;
    assign rsp.status     = rsp_status_reg;
    assign rsp.used_total = rsp_used_reg;
    assign rsp.free_total = rsp_free_reg;

endmodule
